/* rtl/lfsr_rng_with_reseed_and_range_assert.svh */
// Assertion macros shared by the random word generator modules
`ifndef LFSR_RNG_WITH_RESEED_AND_RANGE_ASSERT_SVH
`define LFSR_RNG_WITH_RESEED_AND_RANGE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lrr_pkg.sv */
// Package: widths, register indexes and shared types of the random word generator
package lrr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CNT_W    = 5;

    localparam logic [WORD_W-1:0] RESET_PERIOD = 32'd256;
    localparam logic [WORD_W-1:0] RESET_POLY   = 32'h8000_0057;
    localparam logic [WORD_W-1:0] RESET_LFSR   = 32'hdead_beef;
    localparam logic [WORD_W-1:0] RESET_DRAWS  = 32'hffff_ffff;

    // Configuration register indexes
    localparam logic CFG_RESEED_PERIOD = 1'b0;
    localparam logic CFG_FEEDBACK_POLY = 1'b1;

    // Request type codes
    localparam logic REQ_RAW    = 1'b0;
    localparam logic REQ_RANGED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUSH
    } t_state;

    // How the result value is formed
    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_FLAT,
        KIND_DIV
    } t_kind;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

/* rtl/lrr_req_if.sv */
// Request channel interface: handshake plus request fields
interface lrr_req_if;
    import lrr_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [WORD_W-1:0] range_low;
    logic [WORD_W-1:0] range_high;
    logic [WORD_W-1:0] entropy_word;

    modport source (output valid, req_type, range_low, range_high, entropy_word,
                    input ready);
    modport sink   (input valid, req_type, range_low, range_high, entropy_word,
                    output ready);
endinterface

/* rtl/lrr_rsp_if.sv */
// Response channel interface: handshake plus result fields
interface lrr_rsp_if;
    import lrr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] value;
    logic              reseeded;
    logic              range_error;

    modport source (output valid, value, reseeded, range_error, input ready);
    modport sink   (input valid, value, reseeded, range_error, output ready);
endinterface

/* rtl/lfsr_rng_with_reseed_and_range.sv */
// Random word generator: 32-bit Galois LFSR with periodic reseed and range reduction.
// One request at a time. A request is accepted in the idle state, then the exec state
// classifies it and draws the word (reseed from entropy_word when the draw count has
// reached reseed_period, otherwise one Galois step), then the result is placed in the
// output register. Raw, empty-span, inverted and full-span requests go there
// directly; other ranged requests first pass a radix-2 restoring remainder unit (one
// quotient bit per cycle). The result register lets a finished result wait for the
// consumer while the next request is taken; a request that finishes while the
// previous result is still unread waits in its last step. The user must write
// configuration through the plain write port while idle; the block does not check it.

module lfsr_rng_with_reseed_and_range
    import lrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [WORD_W-1:0] i_cfg_data,
    lrr_req_if.sink           i_req,
    lrr_rsp_if.source         o_rsp
);

    t_cmd cmd;
    t_sts sts;

    lrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lrr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req.req_type),
        .i_range_low    (i_req.range_low),
        .i_range_high   (i_req.range_high),
        .i_entropy_word (i_req.entropy_word),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_value        (o_rsp.value),
        .o_reseeded     (o_rsp.reseeded),
        .o_range_error  (o_rsp.range_error)
    );

endmodule

/* rtl/lrr_ctrl.sv */
// Controller: sequences accept, draw, divide and result hand-off
`include "lfsr_rng_with_reseed_and_range_assert.svh"

module lrr_ctrl
    import lrr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   push_ok;

    // Output register is free when empty or being drained this cycle
    assign push_ok = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.need_div ? ST_DIV : ST_PUSH;
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (push_ok) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: o_cmd.exec     = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_PUSH: o_cmd.push     = push_ok;
            default: o_cmd = '0;
        endcase
    end

    // Fill on push, drain on transaction
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `LRR_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, o_cmd.push, r_out_valid, "push lost result")
    `LRR_ASSERT_NOW(a_push_room, i_clk, i_rst_n, o_cmd.push, push_ok, "push over pending result")
    `LRR_ASSERT_NEXT(a_div_holds, i_clk, i_rst_n, (r_state == ST_DIV) && !i_sts.div_last,
                     r_state == ST_DIV, "divide left early")

endmodule

/* rtl/lrr_dp.sv */
// Datapath: config registers, LFSR, draw counter, radix-2 remainder unit, result register
`include "lfsr_rng_with_reseed_and_range_assert.svh"

module lrr_dp
    import lrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [WORD_W-1:0] i_cfg_data,
    input  logic              i_req_type,
    input  logic [WORD_W-1:0] i_range_low,
    input  logic [WORD_W-1:0] i_range_high,
    input  logic [WORD_W-1:0] i_entropy_word,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [WORD_W-1:0] o_value,
    output logic              o_reseeded,
    output logic              o_range_error
);

    logic [WORD_W-1:0] r_period, r_poly, r_lfsr, r_draws;
    logic [WORD_W-1:0] n_lfsr, n_draws;
    logic              r_type;
    logic [WORD_W-1:0] r_lo, r_hi, r_entropy;
    t_kind             r_kind, n_kind;
    logic              r_reseeded, r_err;
    logic [WORD_W-1:0] r_word, r_dvd, r_mod, r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_value;
    logic              r_out_reseeded, r_out_err;

    logic              inverted, flat, draw, reseed;
    logic [WORD_W-1:0] span, stepped;
    logic [WORD_W:0]   trial, diff;
    logic [WORD_W-1:0] n_rem;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RESET_PERIOD;
            r_poly   <= RESET_POLY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESEED_PERIOD: r_period <= i_cfg_data;
                CFG_FEEDBACK_POLY: r_poly   <= i_cfg_data;
                default:           r_period <= r_period;
            endcase
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_type    <= i_req_type;
            r_lo      <= i_range_low;
            r_hi      <= i_range_high;
            r_entropy <= i_entropy_word;
        end
    end

    // Classify the request
    assign inverted = (r_type == REQ_RANGED) && (r_hi < r_lo);
    assign flat     = (r_type == REQ_RANGED) && (r_hi <= r_lo);
    assign draw     = !flat;
    assign span     = r_hi - r_lo;

    always_comb begin
        if (flat) begin
            n_kind = KIND_FLAT;
        end else if ((r_type == REQ_RAW) || (span == RESET_DRAWS)) begin
            n_kind = KIND_RAW;
        end else begin
            n_kind = KIND_DIV;
        end
    end

    assign o_sts.need_div = (n_kind == KIND_DIV);

    // Reseed or advance the LFSR
    assign reseed  = r_draws >= r_period;
    assign stepped = {1'b0, r_lfsr[WORD_W-1:1]} ^ (r_lfsr[0] ? r_poly : '0);
    assign n_lfsr  = reseed ? r_entropy : stepped;
    assign n_draws = reseed ? '0 : r_draws + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= RESET_LFSR;
            r_draws <= RESET_DRAWS;
        end else if (i_cmd.exec && draw) begin
            r_lfsr  <= n_lfsr;
            r_draws <= n_draws;
        end
    end

    // Restoring remainder step: shift in one dividend bit, subtract if it fits
    assign trial = {r_rem, r_dvd[WORD_W-1]};
    assign diff  = trial - {1'b0, r_mod};
    assign n_rem = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];

    assign o_sts.div_last = (r_cnt == {CNT_W{1'b1}});

    // Capture the drawn word and set up the remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_kind     <= n_kind;
            r_reseeded <= draw && reseed;
            r_err      <= inverted;
            r_word     <= n_lfsr;
            r_dvd      <= n_lfsr;
            r_mod      <= span + 1'b1;
            r_rem      <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            unique case (r_kind)
                KIND_RAW:  r_value <= r_word;
                KIND_FLAT: r_value <= r_lo;
                KIND_DIV:  r_value <= r_lo + r_rem;
                default:   r_value <= r_word;
            endcase
            r_out_reseeded <= r_reseeded;
            r_out_err      <= r_err;
        end
    end

    assign o_value       = r_value;
    assign o_reseeded    = r_out_reseeded;
    assign o_range_error = r_out_err;

    `LRR_ASSERT_NEXT(a_reseed_clears, i_clk, i_rst_n, i_cmd.exec && draw && reseed,
                     r_draws == '0, "reseed left counter set")
    `LRR_ASSERT_NEXT(a_flat_holds, i_clk, i_rst_n, i_cmd.exec && flat,
                     $stable(r_lfsr) && $stable(r_draws), "state moved without a draw")

endmodule

/* sim/tb.sv */
// Testbench for the LFSR random word generator: predictor, scoreboard and drivers
`timescale 1ns / 100ps

module tb
    import lrr_pkg::*;
();

    localparam int unsigned NUM_PHASES       = 8;
    localparam int unsigned RANDOM_PER_PHASE = 240;
    localparam int unsigned HOLD_CYCLES      = 200;
    localparam int unsigned HOLD_MARK_A      = 400;
    localparam int unsigned HOLD_MARK_B      = 1300;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES     = 60;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam logic [WORD_W-1:0] ALL_ONES   = '1;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] range_low;
        logic [WORD_W-1:0] range_high;
        logic [WORD_W-1:0] entropy_word;
    } t_rng_request;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              reseeded;
        logic              range_error;
    } t_rng_result;

    // Word predictor and queue of expected results
    class t_rng_scoreboard;
        logic [WORD_W-1:0] period;
        logic [WORD_W-1:0] poly;
        logic [WORD_W-1:0] lfsr;
        logic [WORD_W-1:0] draws;
        t_rng_result       expected_q[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       reseeds;
        int unsigned       range_errors;

        function new();
            period       = RESET_PERIOD;
            poly         = RESET_POLY;
            lfsr         = RESET_LFSR;
            draws        = RESET_DRAWS;
            errors       = 0;
            checked      = 0;
            reseeds      = 0;
            range_errors = 0;
        endfunction

        function void write_register(logic idx, logic [WORD_W-1:0] data);
            if (idx == CFG_RESEED_PERIOD)
                period = data;
            else
                poly = data;
        endfunction

        // Reseed from entropy when the draw count is due, else take one Galois step
        function logic draw_word(logic [WORD_W-1:0] entropy);
            logic out_bit;
            if (draws >= period) begin
                lfsr  = entropy;
                draws = '0;
                return 1'b1;
            end
            out_bit = lfsr[0];
            lfsr    = lfsr >> 1;
            if (out_bit)
                lfsr = lfsr ^ poly;
            draws = draws + 1'b1;
            return 1'b0;
        endfunction

        function void note_request(t_rng_request r);
            t_rng_result       res;
            logic [WORD_W-1:0] span;
            res   = '0;
            span  = r.range_high - r.range_low;
            if (r.req_type == REQ_RAW) begin
                res.reseeded = draw_word(r.entropy_word);
                res.value    = lfsr;
            end else if (r.range_high < r.range_low) begin
                res.range_error = 1'b1;
                res.value       = r.range_low;
            end else if (r.range_high == r.range_low) begin
                res.value = r.range_low;
            end else begin
                res.reseeded = draw_word(r.entropy_word);
                if (span == ALL_ONES)
                    res.value = lfsr;
                else
                    res.value = r.range_low + lfsr % (span + 1'b1);
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(t_rng_result got);
            t_rng_result exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] unexpected result: value=%h reseeded=%b range_error=%b",
                             $realtime, got.value, got.reseeded, got.range_error);
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (got.reseeded)
                reseeds++;
            if (got.range_error)
                range_errors++;
            if (got.value !== exp_res.value || got.reseeded !== exp_res.reseeded ||
                got.range_error !== exp_res.range_error) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] mismatch on result %0d: expected %h/%b/%b, got %h/%b/%b",
                             $realtime, checked, exp_res.value, exp_res.reseeded,
                             exp_res.range_error, got.value, got.reseeded, got.range_error);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_idx;
    logic [WORD_W-1:0] cfg_data;

    lrr_req_if req_if ();
    lrr_rsp_if rsp_if ();

    t_rng_scoreboard sb = new();

    int unsigned requests_sent  = 0;
    int unsigned requests_taken = 0;
    int unsigned idle_cycles    = 0;
    int unsigned settings_used  = 1;
    bit          sender_burst   = 1'b0;

    lfsr_rng_with_reseed_and_range dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_if),
        .o_rsp     (rsp_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sample both channels, feed the scoreboard, and watch for a hang
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result('{rsp_if.value, rsp_if.reseeded, rsp_if.range_error});
            if (req_if.valid && req_if.ready) begin
                sb.note_request('{req_if.req_type, req_if.range_low, req_if.range_high,
                                  req_if.entropy_word});
                requests_taken++;
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] timeout: no transaction for %0d cycles, %0d results pending",
                         $realtime, idle_cycles, sb.pending());
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic t_rng_request make_request(logic kind, logic [WORD_W-1:0] lo,
                                                  logic [WORD_W-1:0] hi,
                                                  logic [WORD_W-1:0] entropy);
        t_rng_request r;
        r.req_type     = kind;
        r.range_low    = lo;
        r.range_high   = hi;
        r.entropy_word = entropy;
        return r;
    endfunction

    // Mix of raw draws, ordinary ranges and the special range shapes
    function automatic t_rng_request random_request();
        t_rng_request      r;
        int unsigned       pick;
        logic [WORD_W-1:0] span;
        r    = make_request(REQ_RAW, $urandom(), $urandom(), $urandom());
        pick = $urandom_range(99, 0);
        if (pick >= 35) begin
            r.req_type = REQ_RANGED;
            if (pick < 45) begin
                r.range_high = r.range_low;
            end else if (pick < 53) begin
                r.range_low  = $urandom_range(ALL_ONES, 1);
                r.range_high = $urandom_range(r.range_low - 1'b1, 0);
            end else if (pick < 57) begin
                r.range_low  = '0;
                r.range_high = ALL_ONES;
            end else if (pick < 78) begin
                if ($urandom_range(1, 0))
                    span = $urandom_range(16, 1);
                else
                    span = (32'd1 << $urandom_range(31, 1)) - 1'b1;
                r.range_low  = $urandom_range(ALL_ONES - span, 0);
                r.range_high = r.range_low + span;
            end else begin
                r.range_low  = $urandom_range(ALL_ONES - 1'b1, 0);
                r.range_high = $urandom_range(ALL_ONES, r.range_low + 1'b1);
            end
        end
        return r;
    endfunction

    // Offer one request after a random gap and hold it until the block takes it
    task automatic send_request(t_rng_request r);
        int unsigned gap;
        if (requests_sent % 50 == 0)
            sender_burst = ($urandom_range(3, 0) == 0);
        gap = sender_burst ? 0 : $urandom_range(14, 0);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        = 1'b1;
        req_if.req_type     = r.req_type;
        req_if.range_low    = r.range_low;
        req_if.range_high   = r.range_high;
        req_if.entropy_word = r.entropy_word;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
        requests_sent++;
    endtask

    // Take results with random stalls; hold off for a long stretch twice
    task automatic receive_results();
        int unsigned stall;
        int unsigned taken = 0;
        bit          burst = 1'b0;
        forever begin
            if (taken % 40 == 0)
                burst = ($urandom_range(3, 0) == 0);
            stall = burst ? 0 : $urandom_range(14, 0);
            if (taken == HOLD_MARK_A || taken == HOLD_MARK_B)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            @(negedge clk);
            taken++;
        end
    endtask

    task automatic write_register(logic idx, logic [WORD_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        sb.write_register(idx, data);
        @(negedge clk);
    endtask

    // Drain, then reprogram both registers while the block is idle
    task automatic apply_settings(logic [WORD_W-1:0] period, logic [WORD_W-1:0] poly);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_register(CFG_RESEED_PERIOD, period);
        write_register(CFG_FEEDBACK_POLY, poly);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    // Field extremes and every special range shape at reset settings
    task automatic run_directed();
        send_request(make_request(REQ_RAW, '0, '0, ALL_ONES));
        send_request(make_request(REQ_RAW, ALL_ONES, '0, '0));
        send_request(make_request(REQ_RAW, '0, ALL_ONES, 32'h1234_5678));
        send_request(make_request(REQ_RANGED, '0, '0, ALL_ONES));
        send_request(make_request(REQ_RANGED, ALL_ONES, ALL_ONES, '0));
        send_request(make_request(REQ_RANGED, ALL_ONES, '0, ALL_ONES));
        send_request(make_request(REQ_RANGED, 32'd1, '0, '0));
        send_request(make_request(REQ_RANGED, '0, ALL_ONES, ALL_ONES));
        send_request(make_request(REQ_RANGED, '0, 32'd1, '0));
        send_request(make_request(REQ_RANGED, ALL_ONES - 1'b1, ALL_ONES, '0));
        send_request(make_request(REQ_RANGED, '0, ALL_ONES - 1'b1, ALL_ONES));
        send_request(make_request(REQ_RANGED, 32'd1, ALL_ONES, '0));
        send_request(make_request(REQ_RANGED, 32'h8000_0000, ALL_ONES, '0));
        send_request(make_request(REQ_RANGED, '0, 32'd2, '0));
        send_request(make_request(REQ_RANGED, '0, 32'h7fff_ffff, '0));
        send_request(make_request(REQ_RANGED, 32'd100, 32'd100, '0));
        send_request(make_request(REQ_RAW, '0, '0, '0));
        send_request(make_request(REQ_RAW, ALL_ONES, ALL_ONES, ALL_ONES));
        send_request(make_request(REQ_RANGED, 32'd7, 32'd6, ALL_ONES));
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = CFG_RESEED_PERIOD;
        cfg_data            = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_RAW;
        req_if.range_low    = '0;
        req_if.range_high   = '0;
        req_if.entropy_word = '0;
        rsp_if.ready        = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        fork
            receive_results();
        join_none

        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: apply_settings('0, RESET_POLY);
                2: apply_settings(32'd1, $urandom());
                3: apply_settings(ALL_ONES, ALL_ONES);
                4: apply_settings($urandom_range(40, 2), '0);
                5: apply_settings($urandom_range(40, 2), $urandom());
                6: apply_settings(RESET_PERIOD, RESET_POLY);
                7: apply_settings($urandom(), $urandom());
                default: ;
            endcase
            if (phase == 0)
                run_directed();
            for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request());
            req_if.valid = 1'b0;
        end

        // Let every outstanding result arrive, then a little longer
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests under %0d register settings, including two long",
                 requests_taken, settings_used);
        $display("output stalls; %0d results checked, %0d reseeds, %0d range errors, %0d bad",
                 sb.checked, sb.reseeds, sb.range_errors, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
